/* hdl/utrb_pkg.sv */
// ----------------------------------------------------------------------------
// UART ring buffer engine package
// Shared types, constants and pointer helpers for the transmit and receive
// rings, the controller and the datapath.
// ----------------------------------------------------------------------------
package utrb_pkg;

  // Ring geometry
  localparam int unsigned TX_DEPTH = 4096;
  localparam int unsigned RX_DEPTH = 256;
  localparam int unsigned TX_AW    = $clog2(TX_DEPTH);
  localparam int unsigned RX_AW    = $clog2(RX_DEPTH);
  localparam int unsigned TX_PW    = $clog2(2 * TX_DEPTH);
  localparam int unsigned RX_PW    = $clog2(2 * RX_DEPTH);

  // Fixed field widths
  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned TXF_W  = 12;
  localparam int unsigned RXF_W  = 8;

  typedef logic [TX_PW-1:0]  tx_ptr_t;
  typedef logic [RX_PW-1:0]  rx_ptr_t;
  typedef logic [TX_AW-1:0]  tx_idx_t;
  typedef logic [RX_AW-1:0]  rx_idx_t;
  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_LINE  = 2'd2,
    OP_READY = 2'd3
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // first push item: reopen the message
    logic store;    // write one transmit byte at the pending pointer
    logic commit;   // publish the pending pointer, raise the request flag
    logic req_clr;  // drop the request flag
    logic tx_rd;    // read and release the oldest transmit byte
    logic rx_rd;    // read and release the oldest receive byte
    logic rx_wr;    // store a line byte
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic fit;      // offered length fits the free space
    logic len_nz;   // offered length is not zero
    logic open;     // an admitted message is open
    logic rem_nz;   // open message still expects bytes
    logic tx_empty;
    logic rx_empty;
    logic rx_full;
    logic req;
  } stat_t;

  // Read data selection for the response cycle
  typedef struct packed {
    logic sel_tx;
    logic sel_rx;
  } resp_t;

  localparam tx_ptr_t                TX_LAST = TX_PW'(2 * TX_DEPTH - 1);
  localparam tx_ptr_t                TX_DP   = TX_PW'(TX_DEPTH);
  localparam logic [TX_PW:0]         TX_SPAN = (TX_PW + 1)'(2 * TX_DEPTH);
  localparam rx_ptr_t                RX_LAST = RX_PW'(2 * RX_DEPTH - 1);
  localparam rx_ptr_t                RX_DP   = RX_PW'(RX_DEPTH);
  localparam logic [RX_PW:0]         RX_SPAN = (RX_PW + 1)'(2 * RX_DEPTH);

  function automatic tx_ptr_t tx_inc(input tx_ptr_t p);
    return (p == TX_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic tx_idx_t tx_idx(input tx_ptr_t p);
    tx_ptr_t r;
    r = (p >= TX_DP) ? p - TX_DP : p;
    return r[TX_AW-1:0];
  endfunction

  function automatic tx_ptr_t tx_used(input tx_ptr_t h, input tx_ptr_t t);
    logic [TX_PW:0] s;
    s = {1'b0, h} + TX_SPAN - {1'b0, t};
    return (h >= t) ? h - t : s[TX_PW-1:0];
  endfunction

  function automatic rx_ptr_t rx_inc(input rx_ptr_t p);
    return (p == RX_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic rx_idx_t rx_idx(input rx_ptr_t p);
    rx_ptr_t r;
    r = (p >= RX_DP) ? p - RX_DP : p;
    return r[RX_AW-1:0];
  endfunction

  function automatic rx_ptr_t rx_used(input rx_ptr_t h, input rx_ptr_t t);
    logic [RX_PW:0] s;
    s = {1'b0, h} + RX_SPAN - {1'b0, t};
    return (h >= t) ? h - t : s[RX_PW-1:0];
  endfunction

endpackage

/* hdl/uart_tx_rx_ring_buffer_engine.sv */
// ----------------------------------------------------------------------------
// UART transmit/receive ring buffer engine
// Transmit and receive byte rings between a host and a serial line, with
// whole-message admission on the transmit side.
// ----------------------------------------------------------------------------
// The engine takes one transaction in every clock cycle: busy stays low, so
// start may be held high for back-to-back transactions. Each transaction
// gives exactly one result, shown on the result ports for one cycle with
// strobe_o high, in the cycle right after the transaction is accepted. The
// receiver cannot stall; sample the result on that cycle or lose it. The
// result timing is set by the registered read port of each ring store:
// the store is read at the accepting edge and the byte appears in the next
// cycle. Pointers, fills and the request flag shown with a result are the
// values after that transaction. Neither store is cleared by reset, so the
// engine needs no clearing pass and is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffer_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode_i,
  input  logic [utrb_pkg::DATA_W-1:0]  data_in_i,
  input  logic [utrb_pkg::LEN_W-1:0]   message_length_i,
  input  logic                         first_of_message_i,
  input  logic                         last_of_message_i,
  output logic                         strobe_o,
  output logic                         success_o,
  output logic [utrb_pkg::DATA_W-1:0]  data_out_o,
  output logic                         send_valid_o,
  output logic                         transmit_request_o,
  output logic [utrb_pkg::TXF_W-1:0]   transmit_fill_o,
  output logic [utrb_pkg::RXF_W-1:0]   receive_fill_o
);
  import utrb_pkg::*;

  logic  accept;
  cmd_t  cmd;
  stat_t stat;
  resp_t resp;

  // Every transaction completes its state update at the accepting edge, so
  // hold busy low and take a new transaction each cycle.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Decode the transaction and time the result strobe
  utrb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .opcode_i     (op_e'(opcode_i)),
    .first_i      (first_of_message_i),
    .last_i       (last_of_message_i),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .resp_o       (resp),
    .strobe_o     (strobe_o),
    .success_o    (success_o),
    .send_valid_o (send_valid_o)
  );

  // Rings, pointers, message state and request flag
  utrb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .resp_i     (resp),
    .data_i     (data_in_i),
    .length_i   (message_length_i),
    .stat_o     (stat),
    .data_out_o (data_out_o),
    .request_o  (transmit_request_o),
    .tx_fill_o  (transmit_fill_o),
    .rx_fill_o  (receive_fill_o)
  );

endmodule

/* hdl/utrb_ctrl.sv */
// ----------------------------------------------------------------------------
// UART ring buffer controller
// Decodes each accepted transaction into datapath commands and times the
// one-cycle result strobe.
// ----------------------------------------------------------------------------
module utrb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  utrb_pkg::op_e    opcode_i,
  input  logic             first_i,
  input  logic             last_i,
  input  utrb_pkg::stat_t  stat_i,
  output utrb_pkg::cmd_t   cmd_o,
  output utrb_pkg::resp_t  resp_o,
  output logic             strobe_o,
  output logic             success_o,
  output logic             send_valid_o
);
  import utrb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   success_q, success_d;
  logic   send_q, send_d;
  resp_t  resp_q, resp_d;
  logic   admitted;
  logic   rem_nz;

  // Effective admission and remaining count, as seen after a first item
  assign admitted = first_i ? stat_i.fit : stat_i.open;
  assign rem_nz   = first_i ? (stat_i.fit & stat_i.len_nz) : stat_i.rem_nz;

  always_comb begin
    cmd_o     = '0;
    success_d = 1'b0;
    send_d    = 1'b0;
    resp_d    = '0;
    if (accept_i) begin
      unique case (opcode_i)
        OP_PUSH: begin
          cmd_o.load = first_i;
          if (admitted) begin
            success_d    = 1'b1;
            cmd_o.store  = rem_nz;
            cmd_o.commit = last_i;
          end
        end
        OP_POP: begin
          if (!stat_i.rx_empty) begin
            cmd_o.rx_rd   = 1'b1;
            success_d     = 1'b1;
            resp_d.sel_rx = 1'b1;
          end
        end
        OP_LINE: begin
          if (!stat_i.rx_full) begin
            cmd_o.rx_wr = 1'b1;
            success_d   = 1'b1;
          end
        end
        OP_READY: begin
          if (stat_i.req) begin
            if (stat_i.tx_empty) begin
              cmd_o.req_clr = 1'b1;
            end else begin
              cmd_o.tx_rd   = 1'b1;
              success_d     = 1'b1;
              send_d        = 1'b1;
              resp_d.sel_tx = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = accept_i ? ST_RESP : ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      success_q <= 1'b0;
      send_q    <= 1'b0;
      resp_q    <= '0;
    end else begin
      state_q   <= state_d;
      success_q <= success_d;
      send_q    <= send_d;
      resp_q    <= resp_d;
    end
  end

  assign strobe_o     = (state_q == ST_RESP);
  assign success_o    = success_q;
  assign send_valid_o = send_q;
  assign resp_o       = resp_q;

endmodule

/* hdl/utrb_dp.sv */
// ----------------------------------------------------------------------------
// UART ring buffer datapath
// Holds both ring stores, their pointers, the open-message state and the
// request flag; executes controller commands.
// ----------------------------------------------------------------------------
module utrb_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  utrb_pkg::cmd_t                cmd_i,
  input  utrb_pkg::resp_t               resp_i,
  input  logic [utrb_pkg::DATA_W-1:0]   data_i,
  input  logic [utrb_pkg::LEN_W-1:0]    length_i,
  output utrb_pkg::stat_t               stat_o,
  output logic [utrb_pkg::DATA_W-1:0]   data_out_o,
  output logic                          request_o,
  output logic [utrb_pkg::TXF_W-1:0]    tx_fill_o,
  output logic [utrb_pkg::RXF_W-1:0]    rx_fill_o
);
  import utrb_pkg::*;

  byte_t   tx_mem [TX_DEPTH];
  byte_t   rx_mem [RX_DEPTH];
  byte_t   tx_rdata_q, rx_rdata_q;

  tx_ptr_t tx_head_q, tx_head_d;
  tx_ptr_t tx_tail_q, tx_tail_d;
  tx_ptr_t pend_q, pend_d;
  len_t    rem_q, rem_d;
  logic    open_q, open_d;
  rx_ptr_t rx_head_q, rx_head_d;
  rx_ptr_t rx_tail_q, rx_tail_d;
  logic    req_q, req_d;

  tx_ptr_t tx_used_w, space;
  rx_ptr_t rx_used_w;
  tx_ptr_t pend_base, pend_after;
  len_t    rem_base, rem_after;
  logic    open_base;
  logic    fit;

  assign tx_used_w = tx_used(tx_head_q, tx_tail_q);
  assign rx_used_w = rx_used(rx_head_q, rx_tail_q);
  assign space     = TX_PW'(TX_DEPTH - 1) - tx_used_w;
  assign fit       = (32'(length_i) <= 32'(space));

  // Reopen the message on a first item, otherwise carry on
  assign pend_base  = cmd_i.load ? tx_head_q : pend_q;
  assign rem_base   = cmd_i.load ? (fit ? length_i : '0) : rem_q;
  assign open_base  = cmd_i.load ? fit : open_q;
  assign pend_after = cmd_i.store ? tx_inc(pend_base) : pend_base;
  assign rem_after  = cmd_i.store ? rem_base - 1'b1 : rem_base;

  always_comb begin
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    pend_d    = pend_after;
    rem_d     = rem_after;
    open_d    = open_base;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    req_d     = req_q;
    if (cmd_i.commit) begin
      tx_head_d = pend_after;
      open_d    = 1'b0;
      rem_d     = '0;
      req_d     = 1'b1;
    end
    if (cmd_i.req_clr) begin
      req_d = 1'b0;
    end
    if (cmd_i.tx_rd) begin
      tx_tail_d = tx_inc(tx_tail_q);
    end
    if (cmd_i.rx_rd) begin
      rx_tail_d = rx_inc(rx_tail_q);
    end
    if (cmd_i.rx_wr) begin
      rx_head_d = rx_inc(rx_head_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q <= '0;
      tx_tail_q <= '0;
      pend_q    <= '0;
      rem_q     <= '0;
      open_q    <= 1'b0;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      req_q     <= 1'b0;
    end else begin
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      pend_q    <= pend_d;
      rem_q     <= rem_d;
      open_q    <= open_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      req_q     <= req_d;
    end
  end

  // Transmit store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      tx_mem[tx_idx(pend_base)] <= data_i;
    end
    if (cmd_i.tx_rd) begin
      tx_rdata_q <= tx_mem[tx_idx(tx_tail_q)];
    end
  end

  // Receive store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_wr) begin
      rx_mem[rx_idx(rx_head_q)] <= data_i;
    end
    if (cmd_i.rx_rd) begin
      rx_rdata_q <= rx_mem[rx_idx(rx_tail_q)];
    end
  end

  assign stat_o.fit      = fit;
  assign stat_o.len_nz   = (length_i != '0);
  assign stat_o.open     = open_q;
  assign stat_o.rem_nz   = (rem_q != '0);
  assign stat_o.tx_empty = (tx_head_q == tx_tail_q);
  assign stat_o.rx_empty = (rx_head_q == rx_tail_q);
  assign stat_o.rx_full  = (rx_used_w == RX_PW'(RX_DEPTH - 1));
  assign stat_o.req      = req_q;

  assign data_out_o = resp_i.sel_rx ? rx_rdata_q :
                      resp_i.sel_tx ? tx_rdata_q : '0;
  assign request_o  = req_q;
  assign tx_fill_o  = TXF_W'(tx_used_w);
  assign rx_fill_o  = RXF_W'(rx_used_w);

endmodule

/* tb/ring_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring pair scoreboard
// Predicts the result of every accepted transaction of the UART ring buffer
// engine from a private copy of both rings and checks each strobed result
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package ring_scoreboard_pkg;

  import utrb_pkg::*;

  typedef struct packed {
    logic             success;
    byte_t            data;
    logic             send;
    logic             req;
    logic [TXF_W-1:0] tx_fill;
    logic [RXF_W-1:0] rx_fill;
  } ring_result_t;

  class ring_scoreboard;

    byte_t       tx_mem [TX_DEPTH];
    byte_t       rx_mem [RX_DEPTH];
    int unsigned tx_head, tx_tail, pend_ptr, msg_left;
    int unsigned rx_head, rx_tail;
    bit          msg_open, req_flag;
    int unsigned errors;
    ring_result_t awaited_results [$];

    function new();
      tx_head  = 0;
      tx_tail  = 0;
      pend_ptr = 0;
      msg_left = 0;
      rx_head  = 0;
      rx_tail  = 0;
      msg_open = 1'b0;
      req_flag = 1'b0;
      errors   = 0;
    endfunction

    function int unsigned tx_level();
      return (tx_head + 2 * TX_DEPTH - tx_tail) % (2 * TX_DEPTH);
    endfunction

    function int unsigned rx_level();
      return (rx_head + 2 * RX_DEPTH - rx_tail) % (2 * RX_DEPTH);
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    // Advance the private rings by one accepted transaction and queue its result
    function void note_transaction(op_e op, byte_t d, len_t len, logic first, logic last);
      ring_result_t r;
      int unsigned  room;
      r = '0;
      unique case (op)
        OP_PUSH: begin
          if (first) begin
            room     = TX_DEPTH - 1 - tx_level();
            pend_ptr = tx_head;
            msg_open = (len <= room);
            msg_left = msg_open ? len : 0;
          end
          if (msg_open) begin
            r.success = 1'b1;
            if (msg_left > 0) begin
              tx_mem[pend_ptr % TX_DEPTH] = d;
              pend_ptr = (pend_ptr + 1) % (2 * TX_DEPTH);
              msg_left--;
            end
            if (last) begin
              tx_head  = pend_ptr;
              req_flag = 1'b1;
              msg_open = 1'b0;
              msg_left = 0;
            end
          end
        end
        OP_POP: begin
          if (rx_tail != rx_head) begin
            r.data    = rx_mem[rx_tail % RX_DEPTH];
            rx_tail   = (rx_tail + 1) % (2 * RX_DEPTH);
            r.success = 1'b1;
          end
        end
        OP_LINE: begin
          if (rx_level() < RX_DEPTH - 1) begin
            rx_mem[rx_head % RX_DEPTH] = d;
            rx_head   = (rx_head + 1) % (2 * RX_DEPTH);
            r.success = 1'b1;
          end
        end
        default: begin
          if (req_flag) begin
            if (tx_tail == tx_head) begin
              req_flag = 1'b0;
            end else begin
              r.data    = tx_mem[tx_tail % TX_DEPTH];
              tx_tail   = (tx_tail + 1) % (2 * TX_DEPTH);
              r.send    = 1'b1;
              r.success = 1'b1;
            end
          end
        end
      endcase
      r.req     = req_flag;
      r.tx_fill = TXF_W'(tx_level());
      r.rx_fill = RXF_W'(rx_level());
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic succ, byte_t d, logic sv, logic rq,
                               logic [TXF_W-1:0] tf, logic [RXF_W-1:0] rf);
      ring_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with no transaction outstanding, actual data %0h", $time, d);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("success", 12'(want.success), 12'(succ));
      compare_field("data_out", 12'(want.data), 12'(d));
      compare_field("send_valid", 12'(want.send), 12'(sv));
      compare_field("transmit_request", 12'(want.req), 12'(rq));
      compare_field("transmit_fill", want.tx_fill, tf);
      compare_field("receive_fill", 12'(want.rx_fill), 12'(rf));
    endfunction

  endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer engine testbench
// Drives host pushes, host pops, line bytes and transmitter-ready events
// through the start/busy command port, predicts every result with a
// scoreboard and checks the strobed result of each transaction.
// ----------------------------------------------------------------------------
module tb_top;

  import utrb_pkg::*;
  import ring_scoreboard_pkg::*;

  // Generous bound on the length of a run
  localparam int unsigned CYCLE_LIMIT = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        opcode_i;
  byte_t             data_in_i;
  len_t              message_length_i;
  logic              first_of_message_i;
  logic              last_of_message_i;
  logic              strobe_o;
  logic              success_o;
  byte_t             data_out_o;
  logic              send_valid_o;
  logic              transmit_request_o;
  logic [TXF_W-1:0]  transmit_fill_o;
  logic [RXF_W-1:0]  receive_fill_o;

  ring_scoreboard    sb;
  int unsigned       item_count = 0;
  int unsigned       cycles = 0;
  bit                gaps_on = 1'b1;

  uart_tx_rx_ring_buffer_engine dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .data_in_i          (data_in_i),
    .message_length_i   (message_length_i),
    .first_of_message_i (first_of_message_i),
    .last_of_message_i  (last_of_message_i),
    .strobe_o           (strobe_o),
    .success_o          (success_o),
    .data_out_o         (data_out_o),
    .send_valid_o       (send_valid_o),
    .transmit_request_o (transmit_request_o),
    .transmit_fill_o    (transmit_fill_o),
    .receive_fill_o     (receive_fill_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Check every strobed result; values read here are those before the edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && strobe_o === 1'b1)
      sb.check_result(success_o, data_out_o, send_valid_o, transmit_request_o,
                      transmit_fill_o, receive_fill_o);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one transaction and hold it until the engine takes it. The caller
  // must be at a rising edge; start stays high so that the next transaction
  // can follow back to back.
  task automatic send_item(input op_e op, input byte_t d, input len_t len,
                           input logic first, input logic last);
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start              <= 1'b1;
    opcode_i           <= op;
    data_in_i          <= d;
    message_length_i   <= len;
    first_of_message_i <= first;
    last_of_message_i  <= last;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_transaction(op, d, len, first, last);
    item_count++;
  endtask

  // Drop start and hold off until every outstanding result has been checked
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // One stray transaction of a randomly weighted kind, with random fields throughout
  task automatic send_noise(input int unsigned pop_w);
    int unsigned pick;
    op_e         op;
    pick = $urandom_range(0, 99);
    if (pick < pop_w)
      op = OP_POP;
    else if (pick < pop_w + 20)
      op = OP_LINE;
    else if (pick < pop_w + 50)
      op = OP_READY;
    else
      op = OP_PUSH;
    send_item(op, byte_t'($urandom), len_t'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // A push message: half the time well formed, sometimes long with an early commit,
  // over-long, carrying excess bytes, or abandoned without a commit
  task automatic send_message();
    int unsigned kind, n;
    len_t        len;
    bit          commit;
    kind   = $urandom_range(0, 9);
    commit = 1'b1;
    if (kind < 5) begin
      len = len_t'($urandom_range(0, 8));
      n   = (len == 0) ? 1 : len;
    end else if (kind < 7) begin
      len = len_t'($urandom_range(0, 4095));
      n   = $urandom_range(1, 5);
    end else if (kind == 7) begin
      len = len_t'($urandom_range(0, 3));
      n   = len + $urandom_range(1, 3);
    end else if (kind == 8) begin
      len    = len_t'($urandom_range(1, 8));
      n      = $urandom_range(1, len);
      commit = 1'b0;
    end else begin
      len = len_t'($urandom_range(4000, 4095));
      n   = $urandom_range(1, 4);
    end
    for (int unsigned i = 0; i < n; i++)
      send_item(OP_PUSH, byte_t'($urandom), (i == 0) ? len : len_t'($urandom),
                (i == 0), commit && (i == n - 1));
  endtask

  task automatic run_mixed(input int unsigned upto, input int unsigned pop_w);
    while (item_count < upto) begin
      if ($urandom_range(0, 99) < 45)
        send_message();
      else
        send_noise(pop_w);
    end
  endtask

  // Fill the receive ring to the brim and keep offering line bytes past it
  task automatic flood_receive();
    int unsigned drops;
    drops = 0;
    while (sb.rx_level() < RX_DEPTH - 1 || drops < 4) begin
      if ($urandom_range(0, 99) < 8) begin
        send_noise(0);
      end else begin
        if (sb.rx_level() == RX_DEPTH - 1)
          drops++;
        send_item(OP_LINE, byte_t'($urandom), len_t'($urandom), 1'($urandom),
                  1'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    start              = 1'b0;
    opcode_i           = OP_PUSH;
    data_in_i          = '0;
    message_length_i   = '0;
    first_of_message_i = 1'b0;
    last_of_message_i  = 1'b0;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty rings, stray push, zero-length commit, excess bytes,
    // over-long message, exact fit with early commit, reopened message
    send_item(OP_POP,   8'h00, 12'h000, 1'b0, 1'b0);
    send_item(OP_READY, 8'h00, 12'h000, 1'b0, 1'b0);
    send_item(OP_PUSH,  8'hFF, 12'hFFF, 1'b0, 1'b1);
    send_item(OP_PUSH,  8'h12, 12'd0,   1'b1, 1'b1);
    send_item(OP_READY, 8'hFF, 12'hFFF, 1'b1, 1'b1);
    send_item(OP_PUSH,  8'h00, 12'd2,   1'b1, 1'b0);
    send_item(OP_PUSH,  8'hFF, 12'hFFF, 1'b0, 1'b0);
    send_item(OP_PUSH,  8'h3C, 12'h000, 1'b0, 1'b1);
    send_item(OP_PUSH,  8'hA5, 12'd4095, 1'b1, 1'b0);
    send_item(OP_PUSH,  8'h5A, 12'h000, 1'b0, 1'b1);
    send_item(OP_PUSH,  8'h11, 12'd4093, 1'b1, 1'b0);
    send_item(OP_PUSH,  8'h22, 12'h555, 1'b0, 1'b1);
    send_item(OP_PUSH,  8'h33, 12'd5,   1'b1, 1'b0);
    send_item(OP_PUSH,  8'h44, 12'd1,   1'b1, 1'b1);
    send_item(OP_PUSH,  8'h80, 12'd1,   1'b1, 1'b1);
    send_item(OP_READY, 8'h00, 12'h000, 1'b0, 1'b0);
    send_item(OP_READY, 8'h00, 12'h000, 1'b0, 1'b0);
    send_item(OP_READY, 8'h00, 12'h000, 1'b0, 1'b0);
    send_item(OP_LINE,  8'h00, 12'h000, 1'b0, 1'b0);
    send_item(OP_LINE,  8'hFF, 12'hFFF, 1'b1, 1'b1);
    send_item(OP_POP,   8'h00, 12'h000, 1'b0, 1'b0);
    send_item(OP_POP,   8'h00, 12'h000, 1'b0, 1'b0);
    send_item(OP_POP,   8'hFF, 12'hFFF, 1'b1, 1'b1);

    // Random: mixed traffic, then a flood of line bytes with no idling,
    // then pop-heavy traffic that wraps the receive ring
    run_mixed(200, 15);
    wait_for_results();
    gaps_on = 1'b0;
    flood_receive();
    gaps_on = 1'b1;
    wait_for_results();
    run_mixed(570, 40);

    wait_for_results();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
